@@ hdl/spimr_pkg.sv @@
// Shared types and constants for the SPI master register block.
package spimr_pkg;

  // Bus command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_CTRL = 2'd2;

  // Control register bit positions
  localparam int unsigned CTRL_START   = 0;
  localparam int unsigned CTRL_DESEL   = 1;
  localparam int unsigned CTRL_SEL_LSB = 4;

  // Slave select codes
  localparam logic [1:0] SLAVE_ROM  = 2'd0;
  localparam logic [1:0] SLAVE_GPIO = 2'd1;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_LOAD,
    OP_NOP
  } op_kind_e;

  // ROM slave address sequencer
  typedef enum logic [1:0] {
    ROM_ADDR_HI,
    ROM_ADDR_LO,
    ROM_DATA
  } rom_phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  reg_index;
    logic [7:0]  write_byte;
    logic [15:0] load_address;
    logic [7:0]  gpio_in;
  } spi_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       gpio_strobe;
    logic [7:0] gpio_out;
  } spi_rsp_t;

  typedef struct packed {
    op_kind_e    kind;
    logic [1:0]  reg_index;
    logic [7:0]  write_byte;
    logic [15:0] load_address;
    logic [7:0]  gpio_in;
  } op_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

@@ hdl/spimr_front.sv @@
// Request intake: classifies each bus request and pushes it to the queue.
module spimr_front (
  input  logic                  req_valid_i,
  output logic                  req_stall_o,
  input  spimr_pkg::spi_req_t   req_i,
  input  spimr_pkg::queue_stat_t q_stat_i,
  output logic                  push_o,
  output spimr_pkg::op_t        op_o
);
  import spimr_pkg::*;

  assign req_stall_o = q_stat_i.full;
  assign push_o      = req_valid_i && !q_stat_i.full;

  always_comb begin
    op_o.reg_index    = req_i.reg_index;
    op_o.write_byte   = req_i.write_byte;
    op_o.load_address = req_i.load_address;
    op_o.gpio_in      = req_i.gpio_in;
    unique case (req_i.cmd)
      CMD_READ:  op_o.kind = OP_READ;
      CMD_WRITE: op_o.kind = OP_WRITE;
      CMD_LOAD:  op_o.kind = OP_LOAD;
      default:   op_o.kind = OP_NOP;
    endcase
  end

endmodule

@@ hdl/spimr_fifo.sv @@
// Short request queue between the front and the back.
module spimr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  spimr_pkg::op_t         op_i,
  input  logic                   pop_i,
  output spimr_pkg::op_t         op_o,
  output spimr_pkg::queue_stat_t stat_o
);
  import spimr_pkg::*;

  op_t                entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  // Depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wr_ptr_d = wr_ptr_q + (QPTR_W)'(push_i);
    rd_ptr_d = rd_ptr_q + (QPTR_W)'(pop_i);
    count_d  = count_q + (QCNT_W)'(push_i) - (QCNT_W)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o         = entry_q[rd_ptr_q];
  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == (QCNT_W)'(QUEUE_DEPTH));

endmodule

@@ hdl/spimr_back.sv @@
// Execution side: master registers, slave models, ROM store and response register.
module spimr_back #(
  parameter int unsigned ROM_ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spimr_pkg::queue_stat_t q_stat_i,
  input  spimr_pkg::op_t         op_i,
  output logic                   pop_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_stall_i,
  output spimr_pkg::spi_rsp_t    rsp_o
);
  import spimr_pkg::*;

  localparam int unsigned ROM_DEPTH = 1 << ROM_ADDR_BITS;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  dlow_q, dlow_d;
  logic [7:0]  shift_q, shift_d;
  rom_phase_e  phase_q, phase_d;
  logic [15:0] ptr_q, ptr_d;
  logic        pend_q, pend_d;
  logic        rsp_valid_q;
  spi_rsp_t    rsp_q, rsp_d;

  logic [7:0]  mem [ROM_DEPTH];
  logic [7:0]  rom_rdata_q;
  logic        rom_rd_en;
  logic        rom_we;

  logic        out_free;
  logic        do_exec;
  logic [7:0]  wr_ctrl;
  logic [7:0]  wr_dlow;

  assign out_free = !rsp_valid_q || !rsp_stall_i;
  assign do_exec  = q_stat_i.valid && out_free && !pend_q;
  assign pop_o    = do_exec;

  // Register values as seen after this write; high-register writes have no
  // visible effect since that register always reads as zero.
  assign wr_ctrl = (op_i.reg_index == REG_CTRL) ? op_i.write_byte : ctrl_q;
  assign wr_dlow = (op_i.reg_index == REG_LOW)  ? op_i.write_byte : dlow_q;

  always_comb begin
    ctrl_d    = ctrl_q;
    dlow_d    = dlow_q;
    shift_d   = shift_q;
    phase_d   = phase_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    rom_rd_en = 1'b0;
    rom_we    = 1'b0;
    rsp_d     = '0;

    // Land the ROM byte fetched by the previous exchange
    if (pend_q) begin
      shift_d = rom_rdata_q;
    end

    if (do_exec) begin
      unique case (op_i.kind)
        OP_READ: begin
          if (op_i.reg_index == REG_LOW) begin
            rsp_d.read_byte = shift_q;
          end else if (op_i.reg_index == REG_CTRL) begin
            rsp_d.read_byte = ctrl_q & (8'd1 << CTRL_DESEL);
          end
        end
        OP_WRITE: begin
          ctrl_d = wr_ctrl;
          dlow_d = wr_dlow;
          if (wr_ctrl[CTRL_START]) begin
            shift_d = '0;
            case (wr_ctrl[CTRL_SEL_LSB +: 2])
              SLAVE_ROM: begin
                unique case (phase_q)
                  ROM_ADDR_HI: begin
                    ptr_d   = {8'd0, wr_dlow};
                    phase_d = ROM_ADDR_LO;
                  end
                  ROM_ADDR_LO: begin
                    ptr_d   = {ptr_q[7:0], wr_dlow};
                    phase_d = ROM_DATA;
                  end
                  ROM_DATA: begin
                    rom_rd_en = 1'b1;
                    pend_d    = 1'b1;
                    ptr_d     = ptr_q + 16'd1;
                    if (wr_ctrl[CTRL_DESEL]) begin
                      phase_d = ROM_ADDR_HI;
                    end
                  end
                  default: ;
                endcase
              end
              SLAVE_GPIO: begin
                rsp_d.gpio_strobe = 1'b1;
                rsp_d.gpio_out    = wr_dlow;
                shift_d           = op_i.gpio_in;
              end
              default: ;
            endcase
          end
        end
        OP_LOAD: begin
          rom_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      dlow_q      <= '0;
      shift_q     <= '0;
      phase_q     <= ROM_ADDR_HI;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      ctrl_q  <= ctrl_d;
      dlow_q  <= dlow_d;
      shift_q <= shift_d;
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      if (do_exec) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      rsp_q <= rsp_d;
    end
  end

  // ROM store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      mem[op_i.load_address[ROM_ADDR_BITS-1:0]] <= op_i.write_byte;
    end
    if (rom_rd_en) begin
      rom_rdata_q <= mem[ptr_q[ROM_ADDR_BITS-1:0]];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_pend_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("ROM fetch wait lasted more than one cycle");

  a_rom_fetch_sets_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_rd_en |=> pend_q && !do_exec)
    else $error("request executed before ROM byte landed");

  a_gpio_out_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.gpio_strobe |-> rsp_q.gpio_out == 8'd0)
    else $error("gpio_out driven without strobe");

  a_strobe_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.gpio_strobe |-> rsp_q.read_byte == 8'd0)
    else $error("read data on a GPIO exchange");

endmodule

@@ hdl/spi_master_regs_with_rom_slave_core.sv @@
// Top level of the SPI master register block with ROM and GPIO slaves.
// A request passes through the queue and then the response register on its way to rsp_o.
// Throughput: one request per cycle unless the queue is full or the response stalls; a ROM
// data exchange holds the back end while the synchronous ROM read lands in the shift register.
// Reset (rst_ni, async, active low) clears registers, ROM sequencer and queue;
// ROM contents are not cleared and hold garbage until loaded, no clearing pass.
module spi_master_regs_with_rom_slave_core #(
  parameter int unsigned ROM_ADDR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  spimr_pkg::spi_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output spimr_pkg::spi_rsp_t rsp_o
);
  import spimr_pkg::*;

  // Front to queue
  logic        push;
  op_t         push_op;

  // Queue to back
  queue_stat_t q_stat;
  op_t         head_op;
  logic        pop;

  // Classify each request; stall only when the queue is full, so the front
  // keeps taking requests while the back waits on a stalled response.
  spimr_front u_front (
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .op_o        (push_op)
  );

  // Decouple intake from execution so each side can stall on its own.
  spimr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  // Execute in order: master registers, slave exchange, ROM store, and the
  // response register that parts the back end from the consumer.
  spimr_back #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .op_i        (head_op),
    .pop_o       (pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule
